// ===== src/pbb_pkg.sv =====
// shared types, constants and channel functions for the pixel brightness blend block
// no dependencies; used by every module under src
package pbb_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChanMax   = 8'd255;
  localparam logic [8:0] AlphaFull = 9'd256;

  typedef enum logic [1:0] {
    FUNC_BLEND = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_SUB   = 2'd2,
    FUNC_COPY  = 2'd3
  } func_e;

  // what the back end has to do with an item
  typedef enum logic [2:0] {
    OP_OPAQUE = 3'd0,
    OP_KEEP   = 3'd1,
    OP_BLEND  = 3'd2,
    OP_ADD    = 3'd3,
    OP_SUB    = 3'd4
  } op_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    op_e        op;
    logic [8:0] inv;
    pix_t       src;
    pix_t       dst;
  } work_t;

  typedef struct packed {
    pix_t pix;
    logic written;
  } res_t;

  // min(255, (b * (c + 1)) >> 8)
  function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [7:0] b);
    logic [16:0] prod;
    logic [8:0]  shifted;
    prod    = {9'd0, b} * ({9'd0, c} + 17'd1);
    shifted = prod[16:8];
    scale_ch = (shifted > {1'b0, ChanMax}) ? ChanMax : shifted[7:0];
  endfunction

  // (s + ((inv * d) >> 8)) mod 256
  function automatic logic [7:0] blend_ch(input logic [7:0] s, input logic [7:0] d,
                                          input logic [8:0] inv);
    logic [16:0] prod;
    prod = {8'd0, inv} * {9'd0, d};
    blend_ch = s + prod[15:8];
  endfunction

  function automatic logic [7:0] add_sat(input logic [7:0] s, input logic [7:0] d);
    logic [8:0] sum;
    sum = {1'b0, s} + {1'b0, d};
    add_sat = sum[8] ? ChanMax : sum[7:0];
  endfunction

  function automatic logic [7:0] sub_sat(input logic [7:0] s, input logic [7:0] d);
    sub_sat = (d > s) ? (d - s) : 8'd0;
  endfunction

endpackage

// ===== src/pbb_front.sv =====
// front end: accepts items, scales source color by brightness, classifies the operation
// depends on pbb_pkg
module pbb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          func_i,
  input  pbb_pkg::pix_t       src_i,
  input  pbb_pkg::pix_t       dst_i,
  input  logic [7:0]          brightness_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output pbb_pkg::work_t      q_data_o
);

  logic           fv_q, fv_d;
  pbb_pkg::work_t fdata_q, fdata_d;
  pbb_pkg::pix_t  src_s;
  logic           ready, accept;

  assign ready    = !fv_q || !q_full_i;
  assign full_o   = !ready;
  assign accept   = push_i && ready;
  assign q_push_o = fv_q && !q_full_i;
  assign q_data_o = fdata_q;

  always_comb begin
    src_s = src_i;
    if (brightness_i != pbb_pkg::ChanMax) begin
      src_s.red   = pbb_pkg::scale_ch(src_i.red, brightness_i);
      src_s.green = pbb_pkg::scale_ch(src_i.green, brightness_i);
      src_s.blue  = pbb_pkg::scale_ch(src_i.blue, brightness_i);
    end
  end

  always_comb begin
    fdata_d.src = src_s;
    fdata_d.dst = dst_i;
    fdata_d.inv = pbb_pkg::AlphaFull - {1'b0, src_i.alpha};
    case (pbb_pkg::func_e'(func_i))
      pbb_pkg::FUNC_BLEND: begin
        if (src_i.alpha == pbb_pkg::ChanMax) begin
          fdata_d.op = pbb_pkg::OP_OPAQUE;
        end else if (src_i.alpha == 8'd0) begin
          fdata_d.op = pbb_pkg::OP_KEEP;
        end else begin
          fdata_d.op = pbb_pkg::OP_BLEND;
        end
      end
      pbb_pkg::FUNC_ADD:  fdata_d.op = pbb_pkg::OP_ADD;
      pbb_pkg::FUNC_SUB:  fdata_d.op = pbb_pkg::OP_SUB;
      default:            fdata_d.op = pbb_pkg::OP_OPAQUE;
    endcase
  end

  assign fv_d = accept ? 1'b1 : (q_push_o ? 1'b0 : fv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fdata_q <= fdata_d;
    end
  end

  // a held item stays put until the queue takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fv_q && q_full_i) |=> (fv_q && $stable(fdata_q)))
    else $error("front item changed while queue was full");

endmodule

// ===== src/pbb_fifo.sv =====
// short queue between front and back end
// depends on pbb_pkg
module pbb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pbb_pkg::work_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output pbb_pkg::work_t data_o,
  output logic           empty_o
);

  pbb_pkg::work_t                mem_q [pbb_pkg::QDepth];
  logic [pbb_pkg::QPtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [pbb_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == pbb_pkg::QCntW'(pbb_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pbb_pkg::QCntW'(pbb_pkg::QDepth))
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wptr_q - rptr_q) == cnt_q[pbb_pkg::QPtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ===== src/pbb_back.sv =====
// back end: carries out blend, add, subtract or copy and holds the result register
// depends on pbb_pkg
module pbb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  pbb_pkg::work_t q_data_i,
  output logic           q_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output pbb_pkg::res_t  res_o
);

  logic          ov_q, ov_d;
  pbb_pkg::res_t res_q, res_d;
  pbb_pkg::work_t w;

  assign w       = q_data_i;
  assign q_pop_o = !q_empty_i && (!ov_q || pop_i);
  assign empty_o = !ov_q;
  assign res_o   = res_q;

  always_comb begin
    res_d.written   = 1'b1;
    res_d.pix.alpha = pbb_pkg::ChanMax;
    res_d.pix.red   = w.src.red;
    res_d.pix.green = w.src.green;
    res_d.pix.blue  = w.src.blue;
    case (w.op)
      pbb_pkg::OP_OPAQUE: res_d.pix = w.src;
      pbb_pkg::OP_KEEP: begin
        res_d.pix     = w.dst;
        res_d.written = 1'b0;
      end
      pbb_pkg::OP_BLEND: begin
        res_d.pix.red   = pbb_pkg::blend_ch(w.src.red, w.dst.red, w.inv);
        res_d.pix.green = pbb_pkg::blend_ch(w.src.green, w.dst.green, w.inv);
        res_d.pix.blue  = pbb_pkg::blend_ch(w.src.blue, w.dst.blue, w.inv);
      end
      pbb_pkg::OP_ADD: begin
        res_d.pix.red   = pbb_pkg::add_sat(w.src.red, w.dst.red);
        res_d.pix.green = pbb_pkg::add_sat(w.src.green, w.dst.green);
        res_d.pix.blue  = pbb_pkg::add_sat(w.src.blue, w.dst.blue);
      end
      pbb_pkg::OP_SUB: begin
        res_d.pix.red   = pbb_pkg::sub_sat(w.src.red, w.dst.red);
        res_d.pix.green = pbb_pkg::sub_sat(w.src.green, w.dst.green);
        res_d.pix.blue  = pbb_pkg::sub_sat(w.src.blue, w.dst.blue);
      end
      default: res_d.pix = w.src;
    endcase
  end

  assign ov_d = q_pop_o ? 1'b1 : ((ov_q && pop_i) ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  // an untaken result is neither dropped nor overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !pop_i) |=> (ov_q && $stable(res_q)))
    else $error("pending result lost");

  // the back end only takes from the queue when something is there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("pop from empty queue");

endmodule

// ===== src/pixel_brightness_blend.sv =====
// top level of the pixel brightness blend block
// depends on pbb_pkg, pbb_front, pbb_fifo, pbb_back
//
// usage:
//   input side is a queue: drive the item fields and raise push; the item is
//   taken at a clock edge where push is high and full is low
//   result side is a queue: while empty is low the oldest result is on the
//   out_* ports and written_o; it is taken at an edge where pop is high
//   one result per item, in item order
// path: an accepted item passes the front register, then the queue, then the
//   back result register before it shows as a result
// throughput: one item per cycle sustained while pop stays high; the front scales
//   and classifies, the back runs three parallel 9x8 blend multipliers, one pixel a clock
// a 4-deep queue sits between front and back, so a stalled receiver fills the
//   result register, then the queue, then the front register before full rises;
//   up to 6 items can be in flight
// reset: rst_ni is asynchronous, active low; it empties the front register,
//   the queue and the result register; there is no other state
module pixel_brightness_blend (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func_i,
  input  logic [7:0] src_red_i,
  input  logic [7:0] src_green_i,
  input  logic [7:0] src_blue_i,
  input  logic [7:0] src_alpha_i,
  input  logic [7:0] dst_red_i,
  input  logic [7:0] dst_green_i,
  input  logic [7:0] dst_blue_i,
  input  logic [7:0] dst_alpha_i,
  input  logic [7:0] brightness_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o,
  output logic       written_o
);

  pbb_pkg::pix_t  src, dst;
  pbb_pkg::work_t q_wdata, q_rdata;
  pbb_pkg::res_t  res;
  logic           q_push, q_full, q_pop, q_empty;

  // gather the per-channel ports into pixel structs
  assign src = '{red: src_red_i, green: src_green_i, blue: src_blue_i, alpha: src_alpha_i};
  assign dst = '{red: dst_red_i, green: dst_green_i, blue: dst_blue_i, alpha: dst_alpha_i};

  // brightness scaling and operation decode
  pbb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .func_i       (func_i),
    .src_i        (src),
    .dst_i        (dst),
    .brightness_i (brightness_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  // decoupling queue
  pbb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // compositing and result register
  pbb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (res)
  );

  assign out_red_o   = res.pix.red;
  assign out_green_o = res.pix.green;
  assign out_blue_o  = res.pix.blue;
  assign out_alpha_o = res.pix.alpha;
  assign written_o   = res.written;

endmodule

// ===== sim/tb_top.sv =====
// testbench for pixel_brightness_blend: directed and random pixels through the compositor
// depends on pbb_pkg and the pixel_brightness_blend rtl under src
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int          MaxGap     = 17;
  localparam int          DrainWait  = 10;
  localparam int          PrintCap   = 40;

  // one item as the sender sees it
  typedef struct {
    pbb_pkg::func_e func;
    pbb_pkg::pix_t  src;
    pbb_pkg::pix_t  dst;
    logic [7:0]     bright;
  } pixel_req_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] func_i = '0;
  logic [7:0] src_red_i = '0;
  logic [7:0] src_green_i = '0;
  logic [7:0] src_blue_i = '0;
  logic [7:0] src_alpha_i = '0;
  logic [7:0] dst_red_i = '0;
  logic [7:0] dst_green_i = '0;
  logic [7:0] dst_blue_i = '0;
  logic [7:0] dst_alpha_i = '0;
  logic [7:0] brightness_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_red_o;
  logic [7:0] out_green_o;
  logic [7:0] out_blue_o;
  logic [7:0] out_alpha_o;
  logic       written_o;

  // expected composited pixels, oldest first
  pbb_pkg::res_t pending_pixels[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;

  // idle switches for the two sides, flipped by the random phases
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;

  pixel_brightness_blend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .src_red_i   (src_red_i),
    .src_green_i (src_green_i),
    .src_blue_i  (src_blue_i),
    .src_alpha_i (src_alpha_i),
    .dst_red_i   (dst_red_i),
    .dst_green_i (dst_green_i),
    .dst_blue_i  (dst_blue_i),
    .dst_alpha_i (dst_alpha_i),
    .brightness_i(brightness_i),
    .empty       (empty),
    .pop         (pop),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o),
    .written_o   (written_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor: brightness scaling of the source colors, then the compositing
  // function; no state, so each item stands on its own
  // ---------------------------------------------------------------------------
  function automatic pbb_pkg::res_t composite_pixel(input pixel_req_t req);
    pbb_pkg::res_t res;
    logic [7:0]    s [3];
    logic [7:0]    d [3];
    logic [7:0]    o [3];
    int unsigned   lvl;
    int unsigned   sum;
    int unsigned   weight;
    s = '{req.src.red, req.src.green, req.src.blue};
    d = '{req.dst.red, req.dst.green, req.dst.blue};
    // full brightness leaves the source as it is
    if (req.bright != 8'd255) begin
      foreach (s[i]) begin
        lvl  = (int'(req.bright) * (int'(s[i]) + 1)) >> 8;
        s[i] = (lvl > 255) ? 8'd255 : lvl[7:0];
      end
    end
    res.written   = 1'b1;
    res.pix.alpha = 8'd255;
    o = s;
    case (req.func)
      pbb_pkg::FUNC_BLEND: begin
        if (req.src.alpha == 8'd0) begin
          // transparent source: destination echoed, nothing written
          o = d;
          res.pix.alpha = req.dst.alpha;
          res.written   = 1'b0;
        end else if (req.src.alpha != 8'd255) begin
          // premultiplied blend, wraps instead of saturating
          weight = 256 - int'(req.src.alpha);
          foreach (o[i]) begin
            sum  = int'(s[i]) + ((weight * int'(d[i])) >> 8);
            o[i] = sum[7:0];
          end
        end
      end
      pbb_pkg::FUNC_ADD: begin
        foreach (o[i]) begin
          sum  = int'(s[i]) + int'(d[i]);
          o[i] = (sum > 255) ? 8'd255 : sum[7:0];
        end
      end
      pbb_pkg::FUNC_SUB: begin
        foreach (o[i]) o[i] = (d[i] > s[i]) ? d[i] - s[i] : 8'd0;
      end
      pbb_pkg::FUNC_COPY: begin
        res.pix.alpha = req.src.alpha;
      end
      default: ;
    endcase
    res.pix.red   = o[0];
    res.pix.green = o[1];
    res.pix.blue  = o[2];
    return res;
  endfunction

  function automatic pixel_req_t pixel_req(input pbb_pkg::func_e f,
                                           input logic [7:0] sr, input logic [7:0] sg,
                                           input logic [7:0] sb, input logic [7:0] sa,
                                           input logic [7:0] dr, input logic [7:0] dg,
                                           input logic [7:0] db, input logic [7:0] da,
                                           input logic [7:0] b);
    pixel_req_t req;
    req.func   = f;
    req.src    = '{red: sr, green: sg, blue: sb, alpha: sa};
    req.dst    = '{red: dr, green: dg, blue: db, alpha: da};
    req.bright = b;
    return req;
  endfunction

  function automatic int draw_gap(input bit idle_on);
    return idle_on ? $urandom_range(MaxGap, 0) : 0;
  endfunction

  // channel values lean toward the saturation and wrap corners
  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7, 0))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [7:0] rand_alpha();
    case ($urandom_range(7, 0))
      0, 1: return 8'd0;
      2, 3: return 8'd255;
      4: return $urandom_range(1, 0) ? 8'd1 : 8'd254;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t req;
    req.func   = pbb_pkg::func_e'($urandom_range(3, 0));
    req.src    = '{red: rand_channel(), green: rand_channel(), blue: rand_channel(),
                   alpha: rand_alpha()};
    req.dst    = '{red: rand_channel(), green: rand_channel(), blue: rand_channel(),
                   alpha: 8'($urandom_range(255, 0))};
    // a third of the items keep the source at full brightness
    req.bright = ($urandom_range(2, 0) == 0) ? 8'd255 : 8'($urandom_range(255, 0));
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: optional idle gap, then hold the item with push high until the
  // block takes it; the expectation is queued at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input pixel_req_t req);
    int gap;
    gap = draw_gap(src_idle_on);
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push         <= 1'b1;
    func_i       <= req.func;
    src_red_i    <= req.src.red;
    src_green_i  <= req.src.green;
    src_blue_i   <= req.src.blue;
    src_alpha_i  <= req.src.alpha;
    dst_red_i    <= req.dst.red;
    dst_green_i  <= req.dst.green;
    dst_blue_i   <= req.dst.blue;
    dst_alpha_i  <= req.dst.alpha;
    brightness_i <= req.bright;
    do @(posedge clk_i); while (full);
    pending_pixels.insert(pending_pixels.size(), composite_pixel(req));
  endtask

  // receiver: random stall before each item, pop held until one is taken
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(sink_idle_on);
      repeat (gap) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintCap) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // result checker, every item taken off the result side
  always @(posedge clk_i) begin
    pbb_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_red", int'(out_red_o), int'(want.pix.red));
        check_field("out_green", int'(out_green_o), int'(want.pix.green));
        check_field("out_blue", int'(out_blue_o), int'(want.pix.blue));
        check_field("out_alpha", int'(out_alpha_o), int'(want.pix.alpha));
        check_field("written", int'(written_o), int'(want.written));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // alpha blend: opaque, transparent, and the wrapping blend in between
  task automatic test_blend_alpha_cases();
    send_pixel(pixel_req(pbb_pkg::FUNC_BLEND, 8'd10, 8'd200, 8'd255, 8'd255,
                         8'd1, 8'd2, 8'd3, 8'd4, 8'd255));
    send_pixel(pixel_req(pbb_pkg::FUNC_BLEND, 8'd10, 8'd200, 8'd255, 8'd255,
                         8'd9, 8'd8, 8'd7, 8'd6, 8'd100));
    // transparent source must echo the destination, alpha included
    send_pixel(pixel_req(pbb_pkg::FUNC_BLEND, 8'd255, 8'd255, 8'd255, 8'd0,
                         8'd17, 8'd170, 8'd255, 8'd90, 8'd255));
    send_pixel(pixel_req(pbb_pkg::FUNC_BLEND, 8'd0, 8'd0, 8'd0, 8'd0,
                         8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
    // alpha 1 with white on white wraps past 255
    send_pixel(pixel_req(pbb_pkg::FUNC_BLEND, 8'd255, 8'd255, 8'd255, 8'd1,
                         8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(pixel_req(pbb_pkg::FUNC_BLEND, 8'd128, 8'd64, 8'd0, 8'd128,
                         8'd200, 8'd100, 8'd255, 8'd0, 8'd255));
    send_pixel(pixel_req(pbb_pkg::FUNC_BLEND, 8'd255, 8'd1, 8'd30, 8'd254,
                         8'd255, 8'd255, 8'd0, 8'd33, 8'd180));
  endtask

  // add and subtract, at and away from their clamps
  task automatic test_add_sub_saturation();
    send_pixel(pixel_req(pbb_pkg::FUNC_ADD, 8'd255, 8'd255, 8'd255, 8'd0,
                         8'd255, 8'd255, 8'd255, 8'd0, 8'd255));
    send_pixel(pixel_req(pbb_pkg::FUNC_ADD, 8'd0, 8'd100, 8'd200, 8'd77,
                         8'd0, 8'd100, 8'd56, 8'd12, 8'd255));
    send_pixel(pixel_req(pbb_pkg::FUNC_SUB, 8'd255, 8'd0, 8'd50, 8'd255,
                         8'd0, 8'd255, 8'd50, 8'd0, 8'd255));
    send_pixel(pixel_req(pbb_pkg::FUNC_SUB, 8'd0, 8'd255, 8'd1, 8'd3,
                         8'd255, 8'd0, 8'd200, 8'd99, 8'd128));
  endtask

  // copy keeps the source alpha even when it is zero
  task automatic test_opaque_copy();
    send_pixel(pixel_req(pbb_pkg::FUNC_COPY, 8'd11, 8'd22, 8'd33, 8'd0,
                         8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(pixel_req(pbb_pkg::FUNC_COPY, 8'd255, 8'd128, 8'd0, 8'd77,
                         8'd5, 8'd6, 8'd7, 8'd8, 8'd128));
    send_pixel(pixel_req(pbb_pkg::FUNC_COPY, 8'd255, 8'd255, 8'd255, 8'd255,
                         8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
  endtask

  // brightness extremes: black, near full, and the smallest nonzero scale, then mid scales under add and subtract
  task automatic test_brightness_scaling();
    send_pixel(pixel_req(pbb_pkg::FUNC_COPY, 8'd255, 8'd0, 8'd128, 8'd255,
                         8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(pixel_req(pbb_pkg::FUNC_COPY, 8'd255, 8'd0, 8'd128, 8'd255,
                         8'd0, 8'd0, 8'd0, 8'd0, 8'd254));
    send_pixel(pixel_req(pbb_pkg::FUNC_COPY, 8'd255, 8'd254, 8'd127, 8'd200,
                         8'd0, 8'd0, 8'd0, 8'd0, 8'd1));
    send_pixel(pixel_req(pbb_pkg::FUNC_ADD, 8'd255, 8'd255, 8'd255, 8'd9,
                         8'd250, 8'd3, 8'd128, 8'd4, 8'd129));
    send_pixel(pixel_req(pbb_pkg::FUNC_SUB, 8'd255, 8'd255, 8'd255, 8'd9,
                         8'd250, 8'd3, 8'd128, 8'd4, 8'd64));
  endtask

  // random pixels in four phases covering every mix of idle and streaming
  // on the two sides, so the internal queue both fills and runs dry
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      src_idle_on  = (phase == 0) || (phase == 2);
      sink_idle_on = (phase == 0) || (phase == 1);
      repeat (108) send_pixel(random_pixel());
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_blend_alpha_cases();
    test_add_sub_saturation();
    test_opaque_copy();
    test_brightness_scaling();
    test_random_traffic();

    @(negedge clk_i);
    push <= 1'b0;
    // drain, then wait for anything unexpected to show up
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
